@@ src/fpqh_pkg.sv @@
// Shared types and constants for the FASTQ per-position quality histogram.
// Depends on nothing; every other file of the block but fpqh_queue refers to it by scoped names.
`timescale 1ns / 1ps

package fpqh_pkg;

    // Item kinds on the input channel
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] OFFSET_RESET = 8'd33;

    // Fixed payload widths
    localparam int BYTE_W      = 8;
    localparam int RD_POS_W    = 9;
    localparam int RD_SCORE_W  = 7;
    localparam int CELL_W      = 32;
    localparam int LONGEST_W   = 10;

    // Record line currently being parsed
    typedef enum logic [1:0] {
        PHASE_ID,
        PHASE_SEQ,
        PHASE_PLUS,
        PHASE_QUAL
    } line_phase_t;

    // Control half of an operation passed from the parser to the counter engine
    typedef struct packed {
        logic                 is_read;
        logic                 zero;
        logic                 dropped;
        logic [LONGEST_W-1:0] longest;
    } op_flags_t;

endpackage

@@ src/fpqh_item_if.sv @@
// Input channel of the quality histogram: text bytes and cell read requests.
// Depends on fpqh_pkg for the field widths.
`timescale 1ns / 1ps

interface fpqh_item_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [fpqh_pkg::BYTE_W-1:0]        data_byte;
    logic [fpqh_pkg::RD_POS_W-1:0]      read_position;
    logic [fpqh_pkg::RD_SCORE_W-1:0]    read_score;

    modport source (output valid, kind, data_byte, read_position, read_score, input ready);
    modport sink   (input valid, kind, data_byte, read_position, read_score, output ready);
endinterface

@@ src/fpqh_result_if.sv @@
// Result channel of the quality histogram: one cell count with the status.
// Depends on fpqh_pkg for the field widths.
`timescale 1ns / 1ps

interface fpqh_result_if;
    logic                               valid;
    logic                               ready;
    logic [fpqh_pkg::CELL_W-1:0]        cell_count;
    logic [fpqh_pkg::LONGEST_W-1:0]     longest_read;
    logic                               dropped_any;

    modport source (output valid, cell_count, longest_read, dropped_any, input ready);
    modport sink   (input valid, cell_count, longest_read, dropped_any, output ready);
endinterface

@@ src/fpqh_front.sv @@
// Parser front end: tracks the record line, position and drop flag, and turns
// each transfer into a counter increment, a cell read or nothing. Uses fpqh_pkg.
`timescale 1ns / 1ps

module fpqh_front #(
    parameter int MAX_READ_LEN = 512,
    parameter int SCORE_BINS   = 128,
    parameter int ADDR_W       = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fpqh_pkg::BYTE_W-1:0]   cfg_wr_data,
    fpqh_item_if.sink                     items,
    input  logic                          engine_ready,
    input  logic                          q_full,
    output logic                          push,
    output logic [ADDR_W-1:0]             push_addr,
    output fpqh_pkg::op_flags_t           push_flags
);

    localparam int BI_W        = $clog2(MAX_READ_LEN + 1);
    localparam int LW          = fpqh_pkg::LONGEST_W;
    localparam int LONGEST_MAX = (1 << LW) - 1;

    fpqh_pkg::line_phase_t phase_reg, phase_next;
    logic [BI_W-1:0]               base_reg, base_next;
    logic [BI_W-1:0]               max_len_reg, max_len_next;
    logic                          drop_reg, drop_next;
    logic [fpqh_pkg::BYTE_W-1:0]   offset_reg;

    logic                          accept;
    logic                          is_newline;
    logic                          at_cap;
    logic [BI_W-1:0]               base_inc;
    logic [fpqh_pkg::BYTE_W:0]     score_diff;
    logic                          score_ok;
    logic                          read_in_range;
    logic [LW-1:0]                 longest;

    assign items.ready = engine_ready && !q_full;
    assign accept      = items.valid && items.ready;

    assign is_newline = (items.data_byte == fpqh_pkg::NEWLINE_BYTE);
    assign at_cap     = (32'(base_reg) >= MAX_READ_LEN);
    assign base_inc   = base_reg + BI_W'(1);
    assign score_diff = {1'b0, items.data_byte} - {1'b0, offset_reg};
    // A borrow out of the subtraction means the byte sits below the offset
    assign score_ok   = !score_diff[fpqh_pkg::BYTE_W]
                        && (32'(score_diff[fpqh_pkg::BYTE_W-1:0]) < SCORE_BINS);
    assign read_in_range = (32'(items.read_position) < MAX_READ_LEN)
                           && (32'(items.read_score) < SCORE_BINS);
    assign longest = (32'(max_len_reg) > LONGEST_MAX) ? LW'(LONGEST_MAX) : LW'(max_len_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        base_next    = base_reg;
        max_len_next = max_len_reg;
        drop_next    = drop_reg;
        push         = 1'b0;
        push_addr    = '0;
        push_flags   = '{is_read: 1'b0, zero: 1'b0, dropped: drop_reg, longest: longest};

        if (accept)
        begin
            if (items.kind == fpqh_pkg::KIND_READ)
            begin
                push             = 1'b1;
                push_flags.is_read = 1'b1;
                push_flags.zero    = !read_in_range;
                if (read_in_range)
                begin
                    push_addr = ADDR_W'(items.read_position) * ADDR_W'(SCORE_BINS)
                                + ADDR_W'(items.read_score);
                end
            end
            else if (is_newline)
            begin
                phase_next = fpqh_pkg::line_phase_t'(phase_reg + 2'd1);
                base_next  = '0;
            end
            else if (phase_reg == fpqh_pkg::PHASE_QUAL)
            begin
                if (at_cap)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    base_next = base_inc;
                    if (base_inc > max_len_reg)
                    begin
                        max_len_next = base_inc;
                    end
                    if (score_ok)
                    begin
                        push      = 1'b1;
                        push_addr = ADDR_W'(base_reg) * ADDR_W'(SCORE_BINS)
                                    + ADDR_W'(score_diff[fpqh_pkg::BYTE_W-1:0]);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= fpqh_pkg::PHASE_ID;
            base_reg    <= '0;
            max_len_reg <= '0;
            drop_reg    <= 1'b0;
            offset_reg  <= fpqh_pkg::OFFSET_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            base_reg    <= base_next;
            max_len_reg <= max_len_next;
            drop_reg    <= drop_next;
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
        end
    end

endmodule

@@ src/fpqh_queue.sv @@
// Short first-in first-out queue that decouples the parser from the counter engine.
// Generic storage; no package dependency.
`timescale 1ns / 1ps

module fpqh_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (32'(count_reg) == DEPTH);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ src/fpqh_back.sv @@
// Counter engine: owns the histogram memory, clears it after reset, performs
// saturating read-modify-write increments and answers cell reads. Uses fpqh_pkg.
`timescale 1ns / 1ps

module fpqh_back #(
    parameter int COUNT_BITS = 32,
    parameter int DEPTH      = 65536,
    parameter int ADDR_W     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  logic [ADDR_W-1:0]       q_addr,
    input  fpqh_pkg::op_flags_t     q_flags,
    output logic                    pop,
    output logic                    engine_ready,
    fpqh_result_if.source           results
);

    localparam int CW = fpqh_pkg::CELL_W;

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic                  clr_busy_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;

    logic                  s1_valid_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    fpqh_pkg::op_flags_t   s1_flags_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  wr_valid_reg;
    logic [ADDR_W-1:0]     wr_addr_reg;
    logic [COUNT_BITS-1:0] wr_data_reg;

    logic                  out_valid_reg;
    logic [CW-1:0]         out_count_reg;
    logic [fpqh_pkg::LONGEST_W-1:0] out_longest_reg;
    logic                  out_dropped_reg;

    logic                  advance;
    logic                  do_inc;
    logic                  load_out;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [CW-1:0]         cell_sat;

    assign engine_ready = !clr_busy_reg;

    // Only a cell read waiting for the output register can hold the pipeline
    assign advance  = !(s1_valid_reg && s1_flags_reg.is_read && out_valid_reg && !results.ready);
    assign pop      = advance && !q_empty;
    assign do_inc   = s1_valid_reg && !s1_flags_reg.is_read;
    assign load_out = s1_valid_reg && s1_flags_reg.is_read && advance;

    // The write retiring on the same edge as this read is not yet in the read data
    assign cur_count = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg : rd_data_reg;
    assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);

    generate
        if (COUNT_BITS > CW)
        begin : g_wide
            assign cell_sat = (|cur_count[COUNT_BITS-1:CW]) ? '1 : cur_count[CW-1:0];
        end
        else
        begin : g_narrow
            assign cell_sat = CW'(cur_count);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (do_inc)
        begin
            mem[s1_addr_reg] <= inc_count;
        end
        if (pop)
        begin
            rd_data_reg  <= mem[q_addr];
            s1_addr_reg  <= q_addr;
            s1_flags_reg <= q_flags;
        end
        if (do_inc)
        begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= inc_count;
        end
        if (load_out)
        begin
            out_count_reg   <= s1_flags_reg.zero ? '0 : cell_sat;
            out_longest_reg <= s1_flags_reg.longest;
            out_dropped_reg <= s1_flags_reg.dropped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (32'(clr_addr_reg) == DEPTH - 1)
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                end
            end
            if (advance)
            begin
                s1_valid_reg <= pop;
            end
            if (do_inc)
            begin
                wr_valid_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.cell_count   = out_count_reg;
    assign results.longest_read = out_longest_reg;
    assign results.dropped_any  = out_dropped_reg;

endmodule

@@ src/fastq_position_quality_histogram.sv @@
// Per-position quality histogram over a decompressed FASTQ byte stream.
// Depends on fpqh_pkg, the two channel interfaces, fpqh_front, fpqh_queue and fpqh_back.
`timescale 1ns / 1ps

// The block takes one item per clock cycle on the items channel, while its queue
// has room, once its memory clearing pass has finished: after reset it writes
// zero to every one of its MAX_READ_LEN * SCORE_BINS counters (65536 with the
// default parameters), and items.ready stays low for that whole time, although
// the quality offset may be written throughout. A text transfer (kind 0) is
// parsed at once by the front end, which follows the four lines of each record
// by counting newlines; a byte on the quality line becomes a counter increment
// at (position, byte minus offset). A read transfer (kind 1) asks for one counter
// and gives exactly one result transfer, carrying the count together with the
// longest quality line seen and the sticky drop flag as they stood when the read
// was taken. Both kinds sustain one transfer per cycle when nothing stalls: the
// counter engine performs each increment as a read-modify-write over two pipeline
// stages on one memory read port and one write port, and forwards a just-written
// count to a following access to the same counter. A four-entry queue between
// the parser and the engine, and a result register ahead of the results channel,
// let either side stall on its own; a read result that is not taken holds the
// engine, and the queue then fills before items.ready falls. A read transfer
// reaches its result through the queue, the engine's read stage and the result register.

module fastq_position_quality_histogram #(
    parameter int MAX_READ_LEN = 512,
    parameter int SCORE_BINS   = 128,
    parameter int COUNT_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fpqh_pkg::BYTE_W-1:0]   cfg_wr_data,
    fpqh_item_if.sink                     items,
    fpqh_result_if.source                 results
);

    // Counter memory geometry: one row of SCORE_BINS counters per base position
    localparam int DEPTH   = MAX_READ_LEN * SCORE_BINS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FLAGS_W = $bits(fpqh_pkg::op_flags_t);
    localparam int QW      = ADDR_W + FLAGS_W;
    localparam int Q_DEPTH = 4;

    logic                  push;
    logic [ADDR_W-1:0]     push_addr;
    fpqh_pkg::op_flags_t   push_flags;
    logic                  pop;
    logic [QW-1:0]         pop_data;
    logic                  q_full;
    logic                  q_empty;
    logic                  engine_ready;
    logic [ADDR_W-1:0]     q_addr;
    fpqh_pkg::op_flags_t   q_flags;

    // The parser keeps all per-line state, so each item is classified in the
    // cycle it is taken and the engine only ever sees increments and reads.
    fpqh_front #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .SCORE_BINS   (SCORE_BINS),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .items        (items),
        .engine_ready (engine_ready),
        .q_full       (q_full),
        .push         (push),
        .push_addr    (push_addr),
        .push_flags   (push_flags)
    );

    fpqh_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_addr, push_flags}),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign q_addr  = pop_data[QW-1:FLAGS_W];
    assign q_flags = fpqh_pkg::op_flags_t'(pop_data[FLAGS_W-1:0]);

    // The engine also runs the clearing pass and holds the result register.
    fpqh_back #(
        .COUNT_BITS (COUNT_BITS),
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_addr       (q_addr),
        .q_flags      (q_flags),
        .pop          (pop),
        .engine_ready (engine_ready),
        .results      (results)
    );

endmodule
